// ===== hw/rtl/hvt_pkg.sv =====
// Shared types, widths and helpers for the homogeneous vertex transform.
// No dependencies; used by hvt_mac, hvt_div and the top level.
`default_nettype none
package hvt_pkg;

    localparam int DATA_W   = 32;                 // Q16.16 word
    localparam int FRAC_W   = 16;                 // fraction bits
    localparam int NUM_REGS = 8;                  // matrix registers
    localparam int CFG_IDX_W = 8;                 // config index width
    localparam int CFG_W    = 64;                 // config data width
    localparam int PROD_W   = 2 * DATA_W;         // 32x32 product
    localparam int ACC_W    = PROD_W + 2;         // exact column sum
    localparam int SUM_W    = ACC_W - FRAC_W;     // floored column sum
    localparam int REM_W    = SUM_W + FRAC_W;     // scaled numerator
    localparam int QUO_W    = DATA_W + 1;         // quotient bits
    localparam int CMP_W    = SUM_W + QUO_W;      // divisor shifted by up to 32
    localparam int LANES    = 3;                  // x, y, z

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_mat;
    typedef logic [3:0][SUM_W-1:0]          t_cols;

    // Side info that travels with an item through the divider stages
    typedef struct packed {
        logic                          wz;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0]              ovf;
        logic [LANES-1:0]              bsat;
        logic [LANES-1:0][DATA_W-1:0]  byp;
    } t_div_ctl;

    // Matrix entry M[row][col], taken from its packed register
    function automatic logic signed [DATA_W-1:0] entry(input t_mat mat,
                                                       input int row,
                                                       input int col);
        logic [CFG_W-1:0] r;
        r = mat[3'((col * 2) + (row / 2))];
        return (row % 2 == 1) ? $signed(r[2*DATA_W-1:DATA_W])
                              : $signed(r[DATA_W-1:0]);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hvt_mac.sv =====
// Two-stage multiply and column-sum unit: vertex times 4x4 matrix.
// Depends on hvt_pkg.
`default_nettype none
module hvt_mac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire logic signed [31:0]          i_vx,
    input  wire logic signed [31:0]          i_vy,
    input  wire logic signed [31:0]          i_vz,
    input  wire hvt_pkg::t_mat               i_mat,
    output logic                             o_vld,
    output hvt_pkg::t_cols                   o_col
);

    logic signed [hvt_pkg::DATA_W-1:0] w_v [3];
    logic signed [hvt_pkg::PROD_W-1:0] r_prod [4][3];
    logic signed [hvt_pkg::DATA_W-1:0] r_off [4];
    logic                              r_vld_a;
    logic                              r_vld_b;
    logic [hvt_pkg::ACC_W-1:0]         n_acc [4];
    hvt_pkg::t_cols                    r_col;

    assign w_v[0] = i_vx;
    assign w_v[1] = i_vy;
    assign w_v[2] = i_vz;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    // stage A: twelve products and the translation row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[c][k] <= w_v[k] * hvt_pkg::entry(i_mat, k, c);
                end
                r_off[c] <= hvt_pkg::entry(i_mat, 3, c);
            end
        end
    end

    // stage B: exact sum, floored to Q34.16
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_acc[c] = {{2{r_prod[c][0][hvt_pkg::PROD_W-1]}}, r_prod[c][0]}
                     + {{2{r_prod[c][1][hvt_pkg::PROD_W-1]}}, r_prod[c][1]}
                     + {{2{r_prod[c][2][hvt_pkg::PROD_W-1]}}, r_prod[c][2]}
                     + {{(hvt_pkg::ACC_W-hvt_pkg::DATA_W-hvt_pkg::FRAC_W)
                         {r_off[c][hvt_pkg::DATA_W-1]}},
                        r_off[c], {hvt_pkg::FRAC_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_col[c] <= n_acc[c][hvt_pkg::ACC_W-1:hvt_pkg::FRAC_W];
            end
        end
    end

    assign o_vld = r_vld_b;
    assign o_col = r_col;

endmodule
`default_nettype wire

// ===== hw/rtl/hvt_div.sv =====
// Pipelined restoring divider: prep stage, one quotient bit per stage,
// and a saturating output stage. Depends on hvt_pkg.
`default_nettype none
module hvt_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire hvt_pkg::t_cols       i_col,
    output logic                      o_vld,
    output logic [31:0]               o_tx,
    output logic [31:0]               o_ty,
    output logic [31:0]               o_tz,
    output logic                      o_w_was_zero,
    output logic                      o_clipped
);

    localparam int NST = hvt_pkg::QUO_W;  // one stage per quotient bit

    logic                            r_vld [NST+1];
    logic [hvt_pkg::REM_W-1:0]       r_rem [NST+1][hvt_pkg::LANES];
    logic [hvt_pkg::QUO_W-1:0]       r_q   [NST+1][hvt_pkg::LANES];
    logic [hvt_pkg::SUM_W-1:0]       r_d   [NST+1];
    hvt_pkg::t_div_ctl               r_ctl [NST+1];

    logic signed [hvt_pkg::SUM_W-1:0] w_w;
    logic [hvt_pkg::SUM_W-1:0]        w_ad;
    logic [hvt_pkg::SUM_W-1:0]        w_an [hvt_pkg::LANES];
    hvt_pkg::t_div_ctl                n_ctl;

    // prep: magnitudes, signs, zero w, early overflow, undivided result
    assign w_w  = $signed(i_col[3]);
    assign w_ad = w_w[hvt_pkg::SUM_W-1] ? hvt_pkg::SUM_W'(-w_w) : i_col[3];

    always_comb begin
        logic signed [hvt_pkg::SUM_W-1:0] a;
        logic                             hi;
        logic                             lo;
        n_ctl    = '0;
        n_ctl.wz = (w_w == '0);
        for (int k = 0; k < hvt_pkg::LANES; k++) begin
            a = $signed(i_col[k]);
            w_an[k] = a[hvt_pkg::SUM_W-1] ? hvt_pkg::SUM_W'(-a) : i_col[k];
            n_ctl.neg[k] = a[hvt_pkg::SUM_W-1] ^ w_w[hvt_pkg::SUM_W-1];
            n_ctl.ovf[k] = {{(hvt_pkg::QUO_W-hvt_pkg::FRAC_W){1'b0}}, w_an[k]}
                         >= {w_ad, {(hvt_pkg::QUO_W-hvt_pkg::FRAC_W){1'b0}}};
            hi = !a[hvt_pkg::SUM_W-1] && (|a[hvt_pkg::SUM_W-2:hvt_pkg::DATA_W-1]);
            lo = a[hvt_pkg::SUM_W-1] && !(&a[hvt_pkg::SUM_W-2:hvt_pkg::DATA_W-1]);
            n_ctl.bsat[k] = hi || lo;
            n_ctl.byp[k]  = hi ? hvt_pkg::Q_MAX :
                            lo ? hvt_pkg::Q_MIN : a[hvt_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]   <= w_ad;
            r_ctl[0] <= n_ctl;
            for (int k = 0; k < hvt_pkg::LANES; k++) begin
                r_rem[0][k] <= {w_an[k], {hvt_pkg::FRAC_W{1'b0}}};
                r_q[0][k]   <= '0;
            end
        end
    end

    // quotient stages: stage s decides bit NST-1-s
    for (genvar s = 0; s < NST; s++) begin : g_stage
        localparam int B = NST - 1 - s;
        logic [hvt_pkg::CMP_W-1:0] w_sh;
        assign w_sh = {{hvt_pkg::QUO_W{1'b0}}, r_d[s]} << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s+1]   <= r_d[s];
                r_ctl[s+1] <= r_ctl[s];
                for (int k = 0; k < hvt_pkg::LANES; k++) begin
                    if ({{(hvt_pkg::CMP_W-hvt_pkg::REM_W){1'b0}}, r_rem[s][k]} >= w_sh) begin
                        r_rem[s+1][k] <= r_rem[s][k] - w_sh[hvt_pkg::REM_W-1:0];
                        r_q[s+1][k]   <= r_q[s][k] | (hvt_pkg::QUO_W'(1) << B);
                    end else begin
                        r_rem[s+1][k] <= r_rem[s][k];
                        r_q[s+1][k]   <= r_q[s][k];
                    end
                end
            end
        end
    end

    // output stage: sign, saturation, zero-w bypass
    logic [31:0] n_res [hvt_pkg::LANES];
    logic [hvt_pkg::LANES-1:0] n_sat;
    logic                      r_o_vld;
    logic [31:0]               r_res [hvt_pkg::LANES];
    logic                      r_wz;
    logic                      r_clip;

    always_comb begin
        logic [hvt_pkg::QUO_W-1:0] q;
        hvt_pkg::t_div_ctl         c;
        c = r_ctl[NST];
        for (int k = 0; k < hvt_pkg::LANES; k++) begin
            q = r_q[NST][k];
            if (c.wz) begin
                n_res[k] = c.byp[k];
                n_sat[k] = c.bsat[k];
            end else if (c.ovf[k]) begin
                n_res[k] = c.neg[k] ? hvt_pkg::Q_MIN : hvt_pkg::Q_MAX;
                n_sat[k] = 1'b1;
            end else if (c.neg[k]) begin
                n_sat[k] = q > {1'b0, hvt_pkg::Q_MIN};
                n_res[k] = n_sat[k] ? hvt_pkg::Q_MIN : 32'(-q[31:0]);
            end else begin
                n_sat[k] = q > {1'b0, hvt_pkg::Q_MAX};
                n_res[k] = n_sat[k] ? hvt_pkg::Q_MAX : q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= n_res;
            r_wz   <= r_ctl[NST].wz;
            r_clip <= |n_sat;
        end
    end

    assign o_vld        = r_o_vld;
    assign o_tx         = r_res[0];
    assign o_ty         = r_res[1];
    assign o_tz         = r_res[2];
    assign o_w_was_zero = r_wz;
    assign o_clipped    = r_clip;

endmodule
`default_nettype wire

// ===== hw/rtl/homogeneous_vertex_transform.sv =====
// Top level of the vertex transform: matrix registers, flow control,
// hvt_mac and hvt_div. Depends on hvt_pkg, hvt_mac, hvt_div.
//
// Usage:
//  - Input channel i_valid/o_ready carries one vertex (i_vx, i_vy, i_vz),
//    signed Q16.16, per item. Output channel o_valid/i_ready carries
//    o_tx, o_ty, o_tz (Q16.16, saturated), o_w_was_zero and o_clipped.
//  - Config channel i_cfg_valid/o_cfg_ready writes 64-bit matrix register
//    i_cfg_index (0..7, two Q16.16 entries each); higher indexes are
//    dropped. o_cfg_ready is always high. Write only while idle.
//  - The pipe has 37 register stages: two multiply/sum stages, one prep
//    stage, 33 quotient stages (one bit each of the restoring divider) and
//    one output register.
//  - Throughput is one item per cycle unless stalled; every stage advances together.
//  - When the receiver holds i_ready low with a result waiting, the whole
//    pipe freezes and o_ready drops; nothing is lost or repeated.
//  - Reset clears all valid bits and loads the identity matrix.
`default_nettype none
module homogeneous_vertex_transform (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_vx,
    input  wire logic [31:0] i_vy,
    input  wire logic [31:0] i_vz,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_tx,
    output logic [31:0]      o_ty,
    output logic [31:0]      o_tz,
    output logic             o_w_was_zero,
    output logic             o_clipped,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [hvt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hvt_pkg::CFG_W-1:0]     i_cfg_data
);

    hvt_pkg::t_mat  r_mat;
    logic           w_en;
    logic           w_mac_vld;
    hvt_pkg::t_cols w_col;

    // pipe advances unless a result is waiting and not taken
    assign w_en        = !o_valid || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    // matrix registers, identity at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 64'h0000_0000_0001_0000;
            r_mat[1] <= '0;
            r_mat[2] <= 64'h0001_0000_0000_0000;
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= 64'h0000_0000_0001_0000;
            r_mat[6] <= '0;
            r_mat[7] <= 64'h0001_0000_0000_0000;
        end else if (i_cfg_valid && (i_cfg_index < hvt_pkg::CFG_IDX_W'(hvt_pkg::NUM_REGS))) begin
            r_mat[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    hvt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_vx    ($signed(i_vx)),
        .i_vy    ($signed(i_vy)),
        .i_vz    ($signed(i_vz)),
        .i_mat   (r_mat),
        .o_vld   (w_mac_vld),
        .o_col   (w_col)
    );

    hvt_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (w_mac_vld),
        .i_col        (w_col),
        .o_vld        (o_valid),
        .o_tx         (o_tx),
        .o_ty         (o_ty),
        .o_tz         (o_tz),
        .o_w_was_zero (o_w_was_zero),
        .o_clipped    (o_clipped)
    );

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("pipe stalled without a blocked result");

    // an accepted item sits in the first product stage on the next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> u_mac.r_vld_a)
        else $error("accepted item did not move into the pipe");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
